>>> rtl/core/epm_pkg.sv
// Package for the encode performance monitor: payload structs, constants and shared types.
// Depends on nothing; used by every module under rtl/core.
`timescale 1ns / 1ps

package epm_pkg;

    localparam int unsigned TimeBitsDefault      = 48;
    localparam int unsigned WindowSamplesDefault = 32;
    localparam int unsigned StatCount            = 13;

    localparam logic [1:0] REQ_BEGIN   = 2'd0;
    localparam logic [1:0] REQ_END     = 2'd1;
    localparam logic [1:0] REQ_REPORT  = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [3:0] STAT_BUSY_COUNT = 4'd0;
    localparam logic [3:0] STAT_BUSY_AVG   = 4'd1;
    localparam logic [3:0] STAT_BUSY_MIN   = 4'd2;
    localparam logic [3:0] STAT_BUSY_MAX   = 4'd3;
    localparam logic [3:0] STAT_PER_AVG    = 4'd4;
    localparam logic [3:0] STAT_PER_MIN    = 4'd5;
    localparam logic [3:0] STAT_PER_MAX    = 4'd6;
    localparam logic [3:0] STAT_FPS_AVG    = 4'd7;
    localparam logic [3:0] STAT_FPS_MAX    = 4'd8;
    localparam logic [3:0] STAT_KBPS_AVG   = 4'd9;
    localparam logic [3:0] STAT_KBPS_MIN   = 4'd10;
    localparam logic [3:0] STAT_KBPS_MAX   = 4'd11;
    localparam logic [3:0] STAT_KBPS_LAST  = 4'd12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] time_us;
        logic [31:0] bytes_used;
    } epm_in_t;

    typedef struct packed {
        logic [3:0]  stat_id;
        logic [31:0] stat_value;
        logic        last_stat;
    } epm_out_t;

    // Divider width: numerators are at most 64 bits, divisors at most 64 bits.
    localparam int unsigned DivBits = 64;

endpackage

>>> rtl/core/epm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by the monitor.
// Depends on epm_pkg; a zero divisor gives a zero quotient.
`timescale 1ns / 1ps

module epm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [epm_pkg::DivBits-1:0] num,
    input  logic [epm_pkg::DivBits-1:0] den,
    output logic                      done,
    output logic [epm_pkg::DivBits-1:0] quo
);
    import epm_pkg::*;

    localparam int unsigned CntBits = $clog2(DivBits + 1);

    logic [DivBits-1:0] num_reg, num_next;
    logic [DivBits-1:0] den_reg, den_next;
    logic [DivBits:0]   rem_reg, rem_next;
    logic [DivBits-1:0] quo_reg, quo_next;
    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               zero_reg, zero_next;
    logic [DivBits:0]   trial;
    logic [DivBits:0]   shifted;

    // One restoring step: shift in the next numerator bit and try a subtract.
    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        shifted   = {rem_reg[DivBits-1:0], num_reg[DivBits-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CntBits'(DivBits);
            busy_next = 1'b1;
            zero_next = (den == '0);
        end else if (busy_reg) begin
            num_next = {num_reg[DivBits-2:0], 1'b0};
            if (!trial[DivBits]) begin
                rem_next = trial;
                quo_next = {quo_reg[DivBits-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DivBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule

>>> rtl/core/epm_serial_arith.sv
// Bit-serial subtractor for event updates: one bit per cycle.
// Depends on epm_pkg; computes the time delta modulo 2^TIME_BITS serially.
`timescale 1ns / 1ps

module epm_serial_arith #(
    parameter int unsigned TIME_BITS = epm_pkg::TimeBitsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output logic                 done,
    output logic [TIME_BITS-1:0] diff
);
    import epm_pkg::*;

    localparam int unsigned CntBits = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] a_reg, a_next;
    logic [TIME_BITS-1:0] b_reg, b_next;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic                 borrow_reg, borrow_next;
    logic [CntBits-1:0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [1:0]           bit_sum;

    // Least significant bit first, carrying the borrow in a flop.
    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        borrow_next = borrow_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        bit_sum     = {1'b0, a_reg[0]} - {1'b0, b_reg[0]} - {1'b0, borrow_reg};
        if (start) begin
            a_next      = a;
            b_next      = b;
            borrow_next = 1'b0;
            cnt_next    = CntBits'(TIME_BITS);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            a_next      = a_reg >> 1;
            b_next      = b_reg >> 1;
            d_next      = {bit_sum[0], d_reg[TIME_BITS-1:1]};
            borrow_next = bit_sum[1];
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        borrow_reg <= borrow_next;
    end

    assign done = done_reg;
    assign diff = d_reg;

endmodule

>>> rtl/core/encode_perf_monitor_core.sv
// Encode performance monitor, top level: event sequencer, statistics registers, output stage.
// Depends on epm_pkg, epm_serial_arith and epm_div.
`timescale 1ns / 1ps

// Usage
// The s_ channel takes one event item per handshake: frame begin, frame end or
// report. Begin and end items give no result; a report gives 13 result items on
// the m_ channel, stat_id 0 to 12, with last_stat high on the thirteenth.
// An item is worked on alone. Begin and end take a serial time subtract, a
// divide by 100 and a bookkeeping step. A begin that follows an end also passes
// the window check, and one that closes a window adds a bitrate divide.
// A report runs five divides in turn, then sends its 13 result items one at a
// time, each through ST_REP_OUT and then ST_REP_WAIT until the receiver takes it.
// All divides use the one shared bit-serial divider, one quotient bit per cycle.
// A result item sits in an output register; s_ready stays low until the last
// result of a report is taken, so a stalled receiver simply holds the block.
// Reset (aresetn low, synchronous) returns every statistic to its initial
// value: minima all ones, everything else zero. No clearing pass is needed.
module encode_perf_monitor_core #(
    parameter int unsigned WINDOW_SAMPLES = epm_pkg::WindowSamplesDefault,
    parameter int unsigned TIME_BITS      = epm_pkg::TimeBitsDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  epm_pkg::epm_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output epm_pkg::epm_out_t m_data
);
    import epm_pkg::*;

    localparam int unsigned WinBits = $clog2(WINDOW_SAMPLES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_DIV_TIME,
        ST_UPDATE,
        ST_DIV_RATE,
        ST_RATE,
        ST_REP_DIV,
        ST_REP_OUT,
        ST_REP_WAIT
    } state_t;

    state_t state_reg;

    logic [1:0]           req_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]          bytes_reg;
    logic [TIME_BITS-1:0] begin_time_reg;
    logic                 armed_reg;
    logic [31:0]          period_min_reg, period_max_reg, period_total_reg, period_count_reg;
    logic [31:0]          window_time_reg, window_bytes_reg;
    logic [WinBits-1:0]   window_count_reg;
    logic [31:0]          rate_last_reg, rate_min_reg, rate_max_reg;
    logic [31:0]          busy_min_reg, busy_max_reg, busy_total_reg, busy_count_reg;
    logic [31:0]          bytes_total_reg;
    logic [31:0]          elapsed_reg;
    logic [3:0]           sid_reg;
    logic [31:0]          avg_q_reg [5];
    logic [2:0]           qi_reg;
    logic                 rep_go_reg;
    logic                 m_valid_reg;
    epm_out_t             m_data_reg;

    logic                 sub_start, sub_done;
    logic [TIME_BITS-1:0] sub_diff;
    logic                 div_start, div_done;
    logic [DivBits-1:0]   div_num, div_den, div_quo;
    logic [31:0]          p_val;
    logic [31:0]          stat_val;

    epm_serial_arith #(
        .TIME_BITS(TIME_BITS)
    ) u_sub (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sub_start),
        .a      (TIME_BITS'(s_data.time_us)),
        .b      (begin_time_reg),
        .done   (sub_done),
        .diff   (sub_diff)
    );

    epm_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo)
    );

    // Divide operands for each step of the sequence.
    always_comb begin
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            ST_SUB: begin
                div_num = DivBits'(sub_diff);
                div_den = DivBits'(100);
            end
            ST_RATE: begin
                div_num = DivBits'(window_bytes_reg) * DivBits'(80);
                div_den = DivBits'(window_time_reg);
            end
            default: begin
                unique case (qi_reg)
                    3'd0: begin
                        div_num = DivBits'(busy_total_reg);
                        div_den = DivBits'(busy_count_reg);
                    end
                    3'd1: begin
                        div_num = DivBits'(period_total_reg);
                        div_den = DivBits'(period_count_reg);
                    end
                    3'd2: begin
                        div_num = DivBits'(period_count_reg) * DivBits'(100000);
                        div_den = DivBits'(period_total_reg);
                    end
                    3'd3: begin
                        div_num = DivBits'(busy_count_reg) * DivBits'(100000);
                        div_den = DivBits'(busy_total_reg);
                    end
                    3'd4: begin
                        div_num = DivBits'(bytes_total_reg) * DivBits'(80);
                        div_den = DivBits'(period_total_reg);
                    end
                    default: begin
                        div_num = '0;
                        div_den = '0;
                    end
                endcase
            end
        endcase
    end

    assign sub_start = (state_reg == ST_IDLE) && s_valid
                       && ((s_data.req_type == REQ_BEGIN) || (s_data.req_type == REQ_END));
    assign div_start = (state_reg == ST_SUB && sub_done)
                       || (state_reg == ST_RATE
                           && window_count_reg >= WinBits'(WINDOW_SAMPLES)
                           && window_time_reg != 32'd0)
                       || (state_reg == ST_REP_DIV && rep_go_reg);

    assign p_val = elapsed_reg;

    // Pick the statistic for the current id.
    always_comb begin
        unique case (sid_reg)
            STAT_BUSY_COUNT: stat_val = busy_count_reg;
            STAT_BUSY_AVG:   stat_val = avg_q_reg[0];
            STAT_BUSY_MIN:   stat_val = busy_min_reg;
            STAT_BUSY_MAX:   stat_val = busy_max_reg;
            STAT_PER_AVG:    stat_val = avg_q_reg[1];
            STAT_PER_MIN:    stat_val = period_min_reg;
            STAT_PER_MAX:    stat_val = period_max_reg;
            STAT_FPS_AVG:    stat_val = avg_q_reg[2];
            STAT_FPS_MAX:    stat_val = avg_q_reg[3];
            STAT_KBPS_AVG:   stat_val = avg_q_reg[4];
            STAT_KBPS_MIN:   stat_val = rate_min_reg;
            STAT_KBPS_MAX:   stat_val = rate_max_reg;
            default:         stat_val = rate_last_reg;
        endcase
    end

    // Sequencer and statistics registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            begin_time_reg   <= '0;
            armed_reg        <= 1'b0;
            period_min_reg   <= '1;
            period_max_reg   <= '0;
            period_total_reg <= '0;
            period_count_reg <= '0;
            window_time_reg  <= '0;
            window_bytes_reg <= '0;
            window_count_reg <= '0;
            rate_last_reg    <= '0;
            rate_min_reg     <= '1;
            rate_max_reg     <= '0;
            busy_min_reg     <= '1;
            busy_max_reg     <= '0;
            busy_total_reg   <= '0;
            busy_count_reg   <= '0;
            bytes_total_reg  <= '0;
            m_valid_reg      <= 1'b0;
            qi_reg           <= '0;
            rep_go_reg       <= 1'b0;
            sid_reg          <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data.req_type;
                        now_reg   <= TIME_BITS'(s_data.time_us);
                        bytes_reg <= s_data.bytes_used;
                        if (s_data.req_type == REQ_REPORT) begin
                            qi_reg     <= 3'd0;
                            rep_go_reg <= 1'b1;
                            sid_reg    <= STAT_BUSY_COUNT;
                            state_reg  <= ST_REP_DIV;
                        end else if (s_data.req_type != REQ_IGNORED) begin
                            state_reg <= ST_SUB;
                        end
                    end
                end
                ST_SUB: begin
                    if (sub_done) begin
                        state_reg <= ST_DIV_TIME;
                    end
                end
                ST_DIV_TIME: begin
                    if (div_done) begin
                        elapsed_reg <= div_quo[31:0];
                        state_reg   <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    state_reg <= ST_IDLE;
                    if (req_reg == REQ_END) begin
                        if (p_val < busy_min_reg) busy_min_reg <= p_val;
                        if (p_val > busy_max_reg) busy_max_reg <= p_val;
                        busy_total_reg   <= busy_total_reg + p_val;
                        busy_count_reg   <= busy_count_reg + 32'd1;
                        bytes_total_reg  <= bytes_total_reg + bytes_reg;
                        window_bytes_reg <= window_bytes_reg + bytes_reg;
                        armed_reg        <= 1'b1;
                    end else begin
                        begin_time_reg <= now_reg;
                        armed_reg      <= 1'b0;
                        if (armed_reg) begin
                            if (p_val < period_min_reg) period_min_reg <= p_val;
                            if (p_val > period_max_reg) period_max_reg <= p_val;
                            period_total_reg <= period_total_reg + p_val;
                            period_count_reg <= period_count_reg + 32'd1;
                            window_time_reg  <= window_time_reg + p_val;
                            window_count_reg <= window_count_reg + 1'b1;
                            state_reg        <= ST_RATE;
                        end
                    end
                end
                ST_RATE: begin
                    // Window just advanced: close it if full.
                    state_reg <= ST_IDLE;
                    if (window_count_reg >= WinBits'(WINDOW_SAMPLES)) begin
                        if (window_time_reg != 32'd0) begin
                            state_reg <= ST_DIV_RATE;
                        end else begin
                            window_bytes_reg <= '0;
                            window_time_reg  <= '0;
                            window_count_reg <= '0;
                        end
                    end
                end
                ST_DIV_RATE: begin
                    if (div_done) begin
                        rate_last_reg <= div_quo[31:0];
                        if (div_quo[31:0] < rate_min_reg) rate_min_reg <= div_quo[31:0];
                        if (div_quo[31:0] > rate_max_reg) rate_max_reg <= div_quo[31:0];
                        window_bytes_reg <= '0;
                        window_time_reg  <= '0;
                        window_count_reg <= '0;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_REP_DIV: begin
                    // Five quotients in turn, each started in the cycle after the last is stored.
                    if (rep_go_reg) begin
                        rep_go_reg <= 1'b0;
                    end else if (div_done) begin
                        avg_q_reg[qi_reg] <= div_quo[31:0];
                        if (qi_reg == 3'd4) begin
                            state_reg <= ST_REP_OUT;
                        end else begin
                            qi_reg     <= qi_reg + 3'd1;
                            rep_go_reg <= 1'b1;
                        end
                    end
                end
                ST_REP_OUT: begin
                    m_valid_reg           <= 1'b1;
                    m_data_reg.stat_id    <= sid_reg;
                    m_data_reg.stat_value <= stat_val;
                    m_data_reg.last_stat  <= (sid_reg == STAT_KBPS_LAST);
                    state_reg             <= ST_REP_WAIT;
                end
                ST_REP_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (sid_reg == STAT_KBPS_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            sid_reg   <= sid_reg + 4'd1;
                            state_reg <= ST_REP_OUT;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
